### rtl/shqr_pkg.sv
`default_nettype none
package shqr_pkg;

  localparam int DW = 48;
  localparam int YW = 29;
  localparam int SQW = 64;
  localparam int RTW = 32;
  localparam int UW = 33;
  localparam int WW = 32;
  localparam int AXW = 56;
  localparam int MW = 33;
  localparam int PW = 66;
  localparam int SATW = 58;
  localparam int SCALE_BITS = 28;
  localparam int LIMB = 28;
  localparam int QFRAC = 30;
  localparam int KW = 5;
  localparam int SD_CW = 6;
  localparam logic [SD_CW-1:0] SQ_STEPS = 6'd32;
  localparam logic [SD_CW-1:0] DV_STEPS = 6'd31;

  localparam logic signed [DW-1:0] Q_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [DW-1:0] Q_MIN = 48'sh8000_0000_0000;
  localparam logic signed [SATW-1:0] SAT_HI = {{(SATW-DW){1'b0}}, Q_MAX};
  localparam logic signed [SATW-1:0] SAT_LO = {{(SATW-DW){1'b1}}, Q_MIN};
  localparam logic [DW-1:0] EPS_RAW = 48'd1;
  localparam logic [2:0] VAR_RESET = 3'd4;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  localparam logic [1:0] STS_OK = 2'd0;
  localparam logic [1:0] STS_REDUCED = 2'd1;
  localparam logic [1:0] STS_BAD_INDEX = 2'd2;
  localparam logic [1:0] STS_SAT = 2'd3;

  typedef struct packed {
    logic start;
    logic is_div;
  } sd_ctl_t;

  function automatic logic signed [DW-1:0] sat48(input logic signed [SATW-1:0] x);
    if (x > SAT_HI) return Q_MAX;
    else if (x < SAT_LO) return Q_MIN;
    else return x[DW-1:0];
  endfunction

  function automatic logic sat_hit(input logic signed [SATW-1:0] x);
    return (x > SAT_HI) || (x < SAT_LO);
  endfunction

endpackage
`default_nettype wire

### rtl/shqr_mul.sv
`default_nettype none
module shqr_mul (
  input  logic                             clk,
  input  logic signed [shqr_pkg::MW-1:0]   a,
  input  logic signed [shqr_pkg::MW-1:0]   b,
  output logic signed [shqr_pkg::PW-1:0]   p
);
  import shqr_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

### rtl/shqr_sd.sv
`default_nettype none
module shqr_sd (
  input  logic                          clk,
  input  logic                          rst,
  input  shqr_pkg::sd_ctl_t             ctl,
  input  logic [shqr_pkg::SQW-1:0]      rad,
  input  logic [shqr_pkg::RTW-1:0]      mag,
  input  logic [shqr_pkg::RTW-1:0]      den,
  output logic                          done,
  output logic [shqr_pkg::RTW-1:0]      res
);
  import shqr_pkg::*;

  logic             active;
  logic             is_div;
  logic [SD_CW-1:0] cnt;
  logic [SQW-1:0]   sh;
  logic [35:0]      rem;
  logic [RTW-1:0]   den_r;
  logic [35:0]      sq_rem2;
  logic [35:0]      sq_trial;
  logic [35:0]      dv_rem2;
  logic [35:0]      dv_den;

  assign sq_rem2  = {rem[33:0], sh[SQW-1:SQW-2]};
  assign sq_trial = {2'b00, res, 2'b01};
  assign dv_rem2  = {rem[34:0], sh[SQW-1]};
  assign dv_den   = {4'b0000, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!active && ctl.start) begin
        active <= 1'b1;
        is_div <= ctl.is_div;
        res    <= '0;
        if (ctl.is_div) begin
          rem   <= {5'b00000, mag[RTW-1:1]};
          sh    <= {mag[0], {(SQW-1){1'b0}}};
          cnt   <= DV_STEPS;
          den_r <= den;
        end else begin
          rem <= '0;
          sh  <= rad;
          cnt <= SQ_STEPS;
        end
      end else if (active) begin
        if (is_div) begin
          sh <= {sh[SQW-2:0], 1'b0};
          if (dv_rem2 >= dv_den) begin
            rem <= dv_rem2 - dv_den;
            res <= {res[RTW-2:0], 1'b1};
          end else begin
            rem <= dv_rem2;
            res <= {res[RTW-2:0], 1'b0};
          end
        end else begin
          sh <= {sh[SQW-3:0], 2'b00};
          if (sq_rem2 >= sq_trial) begin
            rem <= sq_rem2 - sq_trial;
            res <= {res[RTW-2:0], 1'b1};
          end else begin
            rem <= sq_rem2;
            res <= {res[RTW-2:0], 1'b0};
          end
        end
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/streaming_householder_qr_rows_top.sv
`default_nettype none
// Least-squares row store with in-place Householder QR. An item is taken when start is high,
// busy is low and cfg_we is low; its result appears on read_value and status for exactly one
// cycle with done high, and must be captured then since the receiver cannot stall it. After
// reset and after a cfg write in idle the same clearing pass as for a clear runs with busy high.
// An add that meets a full buffer first reduces it, column by column, with a scaling shift k
// of at most 20, using the shared square-root/divide unit (two roots per column, one divide
// per row from the diagonal down) and the split 33x33 multiplier, each step reading the store
// through its one port.
module streaming_householder_qr_rows_top #(
  parameter int MAX_VARIABLES = 4,
  parameter int EXTRA_ROWS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       opcode,
  input  logic signed [shqr_pkg::DW-1:0]   value,
  input  logic [3:0]                       row_index,
  input  logic [2:0]                       col_index,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_data,
  output logic                             done,
  output logic signed [shqr_pkg::DW-1:0]   read_value,
  output logic [1:0]                       status
);
  import shqr_pkg::*;

  localparam int NCOL_MAX = MAX_VARIABLES + 1;
  localparam int NROW_MAX = NCOL_MAX + EXTRA_ROWS;
  localparam int NENT = NROW_MAX * NCOL_MAX;
  localparam int AW = $clog2(NENT);
  localparam int RIW = $clog2(NROW_MAX + 1);
  localparam int RXW = $clog2(NROW_MAX);
  localparam int CIW = $clog2(NCOL_MAX + 1);

  localparam logic [5:0] ST_IDLE    = 6'd0;
  localparam logic [5:0] ST_CLR     = 6'd1;
  localparam logic [5:0] ST_RDOUT   = 6'd2;
  localparam logic [5:0] ST_ADDW    = 6'd3;
  localparam logic [5:0] ST_MAX_RD  = 6'd4;
  localparam logic [5:0] ST_MAX_AC  = 6'd5;
  localparam logic [5:0] ST_MAX_CHK = 6'd6;
  localparam logic [5:0] ST_KSH     = 6'd7;
  localparam logic [5:0] ST_Y_RD    = 6'd8;
  localparam logic [5:0] ST_Y_AC    = 6'd9;
  localparam logic [5:0] ST_Y_SQ    = 6'd10;
  localparam logic [5:0] ST_Y_MW    = 6'd11;
  localparam logic [5:0] ST_SQ1     = 6'd12;
  localparam logic [5:0] ST_SQ1W    = 6'd13;
  localparam logic [5:0] ST_U0      = 6'd14;
  localparam logic [5:0] ST_U0M     = 6'd15;
  localparam logic [5:0] ST_U0W     = 6'd16;
  localparam logic [5:0] ST_SQ2     = 6'd17;
  localparam logic [5:0] ST_SQ2W    = 6'd18;
  localparam logic [5:0] ST_DV_ST   = 6'd19;
  localparam logic [5:0] ST_DV_GO   = 6'd20;
  localparam logic [5:0] ST_DV_W    = 6'd21;
  localparam logic [5:0] ST_P_RD    = 6'd22;
  localparam logic [5:0] ST_P_LD    = 6'd23;
  localparam logic [5:0] ST_P_AC    = 6'd24;
  localparam logic [5:0] ST_U_RD    = 6'd25;
  localparam logic [5:0] ST_U_LD    = 6'd26;
  localparam logic [5:0] ST_U_WR    = 6'd27;
  localparam logic [5:0] ST_MQ_L    = 6'd28;
  localparam logic [5:0] ST_MQ_H    = 6'd29;
  localparam logic [5:0] ST_MQ_F    = 6'd30;
  localparam logic [5:0] ST_DIAG    = 6'd31;
  localparam logic [5:0] ST_ZERO    = 6'd32;

  function automatic logic [AW-1:0] mem_addr(input logic [31:0] r, input logic [31:0] c);
    logic [31:0] t;
    t = r * NCOL_MAX + c;
    return t[AW-1:0];
  endfunction

  logic [5:0]             state;
  logic [5:0]             ret_state;
  logic [2:0]             var_cfg;
  logic [RIW-1:0]         rows_filled;
  logic [CIW-1:0]         entry_pos;
  logic [CIW-1:0]         ci;
  logic [CIW-1:0]         cl;
  logic [RIW-1:0]         rj;
  logic [AW-1:0]          clr_cnt;
  logic                   emit;
  logic [DW-1:0]          m_reg;
  logic [DW-1:0]          msh;
  logic [KW-1:0]          k;
  logic signed [YW-1:0]   y_reg;
  logic signed [YW-1:0]   y_arr [NROW_MAX];
  logic signed [YW-1:0]   yi;
  logic [SQW-1:0]         yi2;
  logic                   diag_neg;
  logic [SQW-1:0]         s2;
  logic [SQW-1:0]         n2;
  logic [RTW-1:0]         r_reg;
  logic [RTW-1:0]         nu;
  logic signed [UW-1:0]   u0;
  logic [RTW-1:0]         umag;
  logic                   uneg;
  logic signed [WW-1:0]   w_arr [NROW_MAX];
  logic signed [AXW-1:0]  a_reg;
  logic signed [WW-1:0]   w_reg;
  logic signed [PW-1:0]   plo;
  logic signed [AXW-1:0]  mq_reg;
  logic signed [AXW-1:0]  p_acc;
  logic signed [DW-1:0]   d_reg;
  logic signed [DW-1:0]   e_reg;
  logic                   sat_seen;
  logic                   reduced;

  logic signed [DW-1:0]   mem [NENT];
  logic signed [DW-1:0]   rd_data;
  logic [AW-1:0]          mem_ra;
  logic [AW-1:0]          mem_wa;
  logic                   mem_we;
  logic signed [DW-1:0]   mem_wd;

  logic signed [MW-1:0]   mul_a;
  logic signed [MW-1:0]   mul_b;
  logic signed [PW-1:0]   mul_p;
  sd_ctl_t                sd_ctl;
  logic [SQW-1:0]         sd_rad;
  logic                   sd_done;
  logic [RTW-1:0]         sd_res;

  logic [31:0]            vclamp;
  logic [CIW-1:0]         cols_c;
  logic [RIW-1:0]         rows_c;
  logic                   row_last;
  logic                   ci_last;
  logic                   cl_last;
  logic [CIW-1:0]         pos_eff;
  logic                   rd_ok;
  logic signed [SATW-1:0] negv;
  logic [DW-1:0]          rmag;
  logic [DW-1:0]          ysh;
  logic signed [YW-1:0]   ynew;
  logic signed [UW-1:0]   usel;
  logic signed [SATW-1:0] upd;
  logic [51:0]            rho;
  logic signed [SATW-1:0] dval;
  logic signed [87:0]     mq_full;
  logic signed [WW-1:0]   wq;

  always_comb begin
    if (var_cfg == 3'd0) vclamp = 32'd1;
    else if (32'(var_cfg) > 32'(MAX_VARIABLES)) vclamp = 32'(MAX_VARIABLES);
    else vclamp = 32'(var_cfg);
  end

  assign cols_c   = CIW'(vclamp + 32'd1);
  assign rows_c   = RIW'(vclamp + 32'd1 + 32'(EXTRA_ROWS));
  assign row_last = (rj == rows_c - 1'b1);
  assign ci_last  = (ci == cols_c - 1'b1);
  assign cl_last  = (cl == cols_c - 1'b1);
  assign pos_eff  = (entry_pos >= cols_c) ? '0 : entry_pos;
  assign rd_ok    = (32'(row_index) < 32'(rows_c)) && (32'(col_index) < 32'(cols_c));
  assign negv     = -$signed({{(SATW-DW){value[DW-1]}}, value});
  assign rmag     = rd_data[DW-1] ? (~rd_data + 1'b1) : rd_data;
  assign ysh      = rmag >> k;
  assign ynew     = rd_data[DW-1] ? -$signed({1'b0, ysh[YW-2:0]}) : $signed({1'b0, ysh[YW-2:0]});
  assign usel     = (rj == RIW'(ci)) ? u0 : {{(UW-YW){y_arr[rj[RXW-1:0]][YW-1]}},
                                             y_arr[rj[RXW-1:0]]};
  assign upd      = $signed({{(SATW-DW){d_reg[DW-1]}}, d_reg})
                  - $signed({mq_reg[AXW-1], mq_reg, 1'b0});
  assign rho      = 52'(r_reg) << k;
  assign dval     = diag_neg ? $signed({6'b000000, rho}) : -$signed({6'b000000, rho});
  assign mq_full  = ($signed({{(88-PW){mul_p[PW-1]}}, mul_p}) <<< LIMB)
                  + $signed({{(88-PW){plo[PW-1]}}, plo});
  assign wq       = $signed({1'b0, sd_res[WW-2:0]});
  assign busy     = (state != ST_IDLE);

  always_comb begin
    mem_ra = mem_addr(32'(rj), 32'(ci));
    mem_we = 1'b0;
    mem_wa = mem_addr(32'(rj), 32'(ci));
    mem_wd = '0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state)
      ST_IDLE:  mem_ra = mem_addr(32'(row_index), 32'(col_index));
      ST_P_RD,
      ST_U_RD:  mem_ra = mem_addr(32'(rj), 32'(cl));
      ST_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt;
      end
      ST_ADDW: begin
        mem_we = 1'b1;
        mem_wa = mem_addr(32'(rows_filled), 32'(entry_pos));
        mem_wd = e_reg;
      end
      ST_U_WR: begin
        mem_we = 1'b1;
        mem_wa = mem_addr(32'(rj), 32'(cl));
        mem_wd = sat48(upd);
      end
      ST_DIAG: begin
        mem_we = 1'b1;
        mem_wa = mem_addr(32'(ci), 32'(ci));
        mem_wd = sat48(dval);
      end
      ST_ZERO:  mem_we = 1'b1;
      ST_Y_SQ: begin
        mul_a = {{(MW-YW){y_reg[YW-1]}}, y_reg};
        mul_b = {{(MW-YW){y_reg[YW-1]}}, y_reg};
      end
      ST_U0M: begin
        mul_a = u0;
        mul_b = u0;
      end
      ST_MQ_L: begin
        mul_a = $signed({{(MW-LIMB){1'b0}}, a_reg[LIMB-1:0]});
        mul_b = {{(MW-WW){w_reg[WW-1]}}, w_reg};
      end
      ST_MQ_H: begin
        mul_a = {{(MW-(AXW-LIMB)){a_reg[AXW-1]}}, a_reg[AXW-1:LIMB]};
        mul_b = {{(MW-WW){w_reg[WW-1]}}, w_reg};
      end
      default: ;
    endcase
  end

  assign sd_ctl.start  = (state == ST_SQ1) || (state == ST_SQ2) || (state == ST_DV_GO);
  assign sd_ctl.is_div = (state == ST_DV_GO);
  assign sd_rad        = (state == ST_SQ2) ? n2 : s2;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[mem_ra];
  end

  shqr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  shqr_sd u_sd (
    .clk  (clk),
    .rst  (rst),
    .ctl  (sd_ctl),
    .rad  (sd_rad),
    .mag  (umag),
    .den  (nu),
    .done (sd_done),
    .res  (sd_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLR;
      clr_cnt     <= '0;
      emit        <= 1'b0;
      var_cfg     <= VAR_RESET;
      rows_filled <= '0;
      entry_pos   <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cfg_we) begin
            var_cfg     <= cfg_data;
            rows_filled <= '0;
            entry_pos   <= '0;
            clr_cnt     <= '0;
            emit        <= 1'b0;
            state       <= ST_CLR;
          end else if (start) begin
            unique case (opcode)
              OP_ADD: begin
                entry_pos <= pos_eff;
                reduced   <= 1'b0;
                if (pos_eff == cols_c - 1'b1) begin
                  e_reg    <= sat48(negv);
                  sat_seen <= sat_hit(negv);
                end else begin
                  e_reg    <= value;
                  sat_seen <= 1'b0;
                end
                if ((pos_eff == '0) && (rows_filled >= rows_c)) begin
                  ci    <= '0;
                  rj    <= '0;
                  m_reg <= '0;
                  state <= ST_MAX_RD;
                end else begin
                  state <= ST_ADDW;
                end
              end
              OP_READ: begin
                if (rd_ok) begin
                  state <= ST_RDOUT;
                end else begin
                  done       <= 1'b1;
                  read_value <= '0;
                  status     <= STS_BAD_INDEX;
                end
              end
              OP_CLEAR: begin
                rows_filled <= '0;
                entry_pos   <= '0;
                clr_cnt     <= '0;
                emit        <= 1'b1;
                state       <= ST_CLR;
              end
              OP_NOP: begin
                done       <= 1'b1;
                read_value <= '0;
                status     <= STS_OK;
              end
            endcase
          end
        end
        ST_CLR: begin
          if (cfg_we) var_cfg <= cfg_data;
          clr_cnt <= clr_cnt + 1'b1;
          if (32'(clr_cnt) == 32'(NENT - 1)) begin
            state <= ST_IDLE;
            if (emit) begin
              done       <= 1'b1;
              read_value <= '0;
              status     <= STS_OK;
            end
          end
        end
        ST_RDOUT: begin
          done       <= 1'b1;
          read_value <= rd_data;
          status     <= STS_OK;
          state      <= ST_IDLE;
        end
        ST_ADDW: begin
          if (entry_pos == cols_c - 1'b1) begin
            entry_pos   <= '0;
            rows_filled <= rows_filled + 1'b1;
          end else begin
            entry_pos <= entry_pos + 1'b1;
          end
          done       <= 1'b1;
          read_value <= '0;
          status     <= sat_seen ? STS_SAT : (reduced ? STS_REDUCED : STS_OK);
          state      <= ST_IDLE;
        end
        ST_MAX_RD: state <= ST_MAX_AC;
        ST_MAX_AC: begin
          if (rmag > m_reg) m_reg <= rmag;
          if (row_last) begin
            state <= ST_MAX_CHK;
          end else begin
            rj    <= rj + 1'b1;
            state <= ST_MAX_RD;
          end
        end
        ST_MAX_CHK: begin
          if (m_reg <= EPS_RAW) begin
            rj    <= RIW'(ci) + 1'b1;
            state <= ST_ZERO;
          end else begin
            msh   <= m_reg;
            k     <= '0;
            state <= ST_KSH;
          end
        end
        ST_KSH: begin
          if (|msh[DW-1:SCALE_BITS]) begin
            msh <= msh >> 1;
            k   <= k + 1'b1;
          end else begin
            rj    <= RIW'(ci);
            s2    <= '0;
            state <= ST_Y_RD;
          end
        end
        ST_Y_RD: state <= ST_Y_AC;
        ST_Y_AC: begin
          y_reg               <= ynew;
          y_arr[rj[RXW-1:0]] <= ynew;
          if (rj == RIW'(ci)) begin
            yi       <= ynew;
            diag_neg <= rd_data[DW-1];
          end
          state <= ST_Y_SQ;
        end
        ST_Y_SQ: state <= ST_Y_MW;
        ST_Y_MW: begin
          s2 <= s2 + mul_p[SQW-1:0];
          if (rj == RIW'(ci)) yi2 <= mul_p[SQW-1:0];
          if (row_last) begin
            state <= ST_SQ1;
          end else begin
            rj    <= rj + 1'b1;
            state <= ST_Y_RD;
          end
        end
        ST_SQ1: state <= ST_SQ1W;
        ST_SQ1W: begin
          if (sd_done) begin
            r_reg <= sd_res;
            state <= ST_U0;
          end
        end
        ST_U0: begin
          if (diag_neg) u0 <= {{(UW-YW){yi[YW-1]}}, yi} - $signed({1'b0, r_reg});
          else u0 <= {{(UW-YW){yi[YW-1]}}, yi} + $signed({1'b0, r_reg});
          state <= ST_U0M;
        end
        ST_U0M: state <= ST_U0W;
        ST_U0W: begin
          n2    <= mul_p[SQW-1:0] + s2 - yi2;
          state <= ST_SQ2;
        end
        ST_SQ2: state <= ST_SQ2W;
        ST_SQ2W: begin
          if (sd_done) begin
            nu    <= (sd_res == '0) ? RTW'(1) : sd_res;
            rj    <= RIW'(ci);
            state <= ST_DV_ST;
          end
        end
        ST_DV_ST: begin
          uneg  <= usel[UW-1];
          umag  <= usel[UW-1] ? RTW'(-usel) : RTW'(usel);
          state <= ST_DV_GO;
        end
        ST_DV_GO: state <= ST_DV_W;
        ST_DV_W: begin
          if (sd_done) begin
            w_arr[rj[RXW-1:0]] <= uneg ? -wq : wq;
            if (row_last) begin
              if (ci_last) begin
                state <= ST_DIAG;
              end else begin
                cl    <= ci + 1'b1;
                rj    <= RIW'(ci);
                p_acc <= '0;
                state <= ST_P_RD;
              end
            end else begin
              rj    <= rj + 1'b1;
              state <= ST_DV_ST;
            end
          end
        end
        ST_P_RD: state <= ST_P_LD;
        ST_P_LD: begin
          a_reg     <= {{(AXW-DW){rd_data[DW-1]}}, rd_data};
          w_reg     <= w_arr[rj[RXW-1:0]];
          ret_state <= ST_P_AC;
          state     <= ST_MQ_L;
        end
        ST_P_AC: begin
          p_acc <= p_acc + mq_reg;
          if (row_last) begin
            rj    <= RIW'(ci);
            state <= ST_U_RD;
          end else begin
            rj    <= rj + 1'b1;
            state <= ST_P_RD;
          end
        end
        ST_U_RD: state <= ST_U_LD;
        ST_U_LD: begin
          d_reg     <= rd_data;
          a_reg     <= p_acc;
          w_reg     <= w_arr[rj[RXW-1:0]];
          ret_state <= ST_U_WR;
          state     <= ST_MQ_L;
        end
        ST_U_WR: begin
          if (sat_hit(upd)) sat_seen <= 1'b1;
          if (row_last) begin
            if (cl_last) begin
              state <= ST_DIAG;
            end else begin
              cl    <= cl + 1'b1;
              rj    <= RIW'(ci);
              p_acc <= '0;
              state <= ST_P_RD;
            end
          end else begin
            rj    <= rj + 1'b1;
            state <= ST_U_RD;
          end
        end
        ST_MQ_L: state <= ST_MQ_H;
        ST_MQ_H: begin
          plo   <= mul_p;
          state <= ST_MQ_F;
        end
        ST_MQ_F: begin
          mq_reg <= mq_full[QFRAC+AXW-1:QFRAC];
          state  <= ret_state;
        end
        ST_DIAG: begin
          if (sat_hit(dval)) sat_seen <= 1'b1;
          rj    <= RIW'(ci) + 1'b1;
          state <= ST_ZERO;
        end
        ST_ZERO: begin
          if (row_last) begin
            if (ci_last) begin
              rows_filled <= RIW'(cols_c);
              reduced     <= 1'b1;
              state       <= ST_ADDW;
            end else begin
              ci    <= ci + 1'b1;
              rj    <= RIW'(ci) + 1'b1;
              m_reg <= '0;
              state <= ST_MAX_RD;
            end
          end else begin
            rj <= rj + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_sd_done_waited: assert property (@(posedge clk) disable iff (rst)
    sd_done |-> (state == ST_SQ1W || state == ST_SQ2W || state == ST_DV_W))
    else $error("root/divide unit finished outside a wait state");

  a_rows_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (rows_filled <= rows_c))
    else $error("row count beyond buffer size");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result strobe without an item");

endmodule
`default_nettype wire
